@@ sv/kpsdr_pkg.sv @@
`default_nettype none

package kpsdr_pkg;

  // Keypad geometry
  localparam int KEY_ROWS = 4;
  localparam int KEY_COLS = 4;

  // Field widths
  localparam int MAP_W    = 16;
  localparam int TICK_W   = 32;
  localparam int MS_W     = 16;
  localparam int POS_W    = 4;
  localparam int KEY_W    = 5;
  localparam int CHAR_W   = 7;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEBOUNCE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_REPEAT   = 8'd1;

  // Register reset values
  localparam logic [MS_W-1:0] DEBOUNCE_RST = 16'd20;
  localparam logic [MS_W-1:0] REPEAT_RST   = 16'd200;

  typedef logic [MAP_W-1:0]      key_map_t;
  typedef logic [TICK_W-1:0]     tick_t;
  typedef logic [MS_W-1:0]       ms_t;
  typedef logic [POS_W-1:0]      key_pos_t;
  typedef logic [KEY_W-1:0]      key_code_t;
  typedef logic [CHAR_W-1:0]     key_char_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // ASCII legends, row by row
  localparam logic [CHAR_W-1:0] LEGEND [4][4] = '{
    '{7'h31, 7'h32, 7'h33, 7'h41},
    '{7'h34, 7'h35, 7'h36, 7'h42},
    '{7'h37, 7'h38, 7'h39, 7'h43},
    '{7'h2A, 7'h30, 7'h23, 7'h44}
  };

  // First pressed key, columns outer and rows inner; position+1, 0 when none
  function automatic key_code_t scan_first(key_map_t map);
    key_code_t res;
    int        pos;
    res = '0;
    for (int c = KEY_COLS - 1; c >= 0; c--) begin
      for (int r = KEY_ROWS - 1; r >= 0; r--) begin
        pos = r * KEY_COLS + c;
        if (pos < MAP_W) begin
          if (map[pos[POS_W-1:0]]) begin
            res = KEY_W'(pos + 1);
          end
        end
      end
    end
    return res;
  endfunction

  // Legend of a position, 0 outside the table
  function automatic key_char_t legend_of(key_pos_t pos);
    int        r;
    int        c;
    key_char_t ch;
    r  = int'(pos) / KEY_COLS;
    c  = int'(pos) % KEY_COLS;
    ch = '0;
    if (r < 4 && c < 4) begin
      ch = LEGEND[r[1:0]][c[1:0]];
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

@@ sv/kpsdr_if.sv @@
`default_nettype none

// Poll word: key map and tick
interface kpsdr_in_if;
  logic               valid;
  logic               ready;
  kpsdr_pkg::key_map_t key_map;
  kpsdr_pkg::tick_t    now_ms;

  modport source (output valid, output key_map, output now_ms, input ready);
  modport sink   (input valid, input key_map, input now_ms, output ready);
endinterface

// Result word: reported key
interface kpsdr_out_if;
  logic                 valid;
  logic                 ready;
  logic                 key_valid;
  kpsdr_pkg::key_pos_t  key_index;
  kpsdr_pkg::key_char_t key_char;

  modport source (output valid, output key_valid, output key_index, output key_char,
                  input ready);
  modport sink   (input valid, input key_valid, input key_index, input key_char,
                  output ready);
endinterface

// Register write word
interface kpsdr_cfg_if;
  logic                 valid;
  logic                 ready;
  kpsdr_pkg::cfg_idx_t  index;
  kpsdr_pkg::cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/keypad_scan_debounce_repeat_core.sv @@
// A poll word is captured in the input register, and its result word is then registered in
// the result register when both stages advance.
// Throughput: one poll per cycle while results are taken; the input register and the result
// register advance together, so a stalled result holds one poll in the input register behind it.
// The scan, debounce and repeat decisions are one pass of logic between those registers.
// Reset (rst_ni low, asynchronous): both registers empty, no pending or reported key,
// ticks 0, debounce 20 ms, repeat 200 ms.
`default_nettype none

module keypad_scan_debounce_repeat_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  kpsdr_cfg_if.sink         cfg_i,
  kpsdr_in_if.sink          in_i,
  kpsdr_out_if.source       out_o
);
  import kpsdr_pkg::*;

  ms_t       debounce_q;
  ms_t       repeat_q;

  logic      s1_valid_q;
  key_map_t  s1_map_q;
  tick_t     s1_now_q;

  key_code_t pend_key_q, pend_key_d;
  tick_t     pend_since_q, pend_since_d;
  key_code_t rep_key_q, rep_key_d;
  tick_t     rep_at_q, rep_at_d;

  logic      out_valid_q;
  logic      out_key_valid_q;
  key_pos_t  out_index_q;
  key_char_t out_char_q;

  logic      advance;
  logic      s1_fire;
  logic      in_fire;
  key_code_t key;
  key_pos_t  key_pos;
  tick_t     pend_age;
  tick_t     rep_age;
  logic      report;

  // Handshake: both stages move when the result register is free or drains
  assign advance     = !out_valid_q || out_o.ready;
  assign s1_fire     = s1_valid_q && advance;
  assign in_i.ready  = !s1_valid_q || advance;
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // Write configuration registers; ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RST;
      repeat_q   <= REPEAT_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_IDX_DEBOUNCE) begin
        debounce_q <= cfg_i.data[MS_W-1:0];
      end else if (cfg_i.index == CFG_IDX_REPEAT) begin
        repeat_q <= cfg_i.data[MS_W-1:0];
      end
    end
  end

  // Capture the poll word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_map_q <= in_i.key_map;
      s1_now_q <= in_i.now_ms;
    end
  end

  // Scan and time checks
  assign key      = scan_first(s1_map_q);
  assign key_pos  = key_pos_t'(key - key_code_t'(1));
  assign pend_age = s1_now_q - pend_since_q;
  assign rep_age  = s1_now_q - rep_at_q;
  assign report   = (key != '0) && (key == pend_key_q) &&
                    (pend_age > {16'b0, debounce_q}) &&
                    ((rep_age > {16'b0, repeat_q}) || (rep_key_q != key));

  // Next debounce and repeat state
  always_comb begin
    pend_key_d   = pend_key_q;
    pend_since_d = pend_since_q;
    rep_key_d    = rep_key_q;
    rep_at_d     = rep_at_q;
    if (s1_fire) begin
      if (key == '0) begin
        pend_key_d   = '0;
        pend_since_d = '0;
      end else if (key != pend_key_q) begin
        pend_key_d   = key;
        pend_since_d = s1_now_q;
      end else if (report) begin
        rep_key_d    = key;
        rep_at_d     = s1_now_q;
        pend_since_d = s1_now_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_key_q   <= '0;
      pend_since_q <= '0;
      rep_key_q    <= '0;
      rep_at_q     <= '0;
    end else begin
      pend_key_q   <= pend_key_d;
      pend_since_q <= pend_since_d;
      rep_key_q    <= rep_key_d;
      rep_at_q     <= rep_at_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_key_valid_q <= report;
      out_index_q     <= report ? key_pos : '0;
      out_char_q      <= report ? legend_of(key_pos) : '0;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.key_valid = out_key_valid_q;
  assign out_o.key_index = out_index_q;
  assign out_o.key_char  = out_char_q;

endmodule

`default_nettype wire

@@ sv/kpsdr_checker.sv @@
`default_nettype none

module kpsdr_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic                 out_key_valid_i,
  input kpsdr_pkg::key_pos_t  out_key_index_i,
  input kpsdr_pkg::key_char_t out_key_char_i
);
  import kpsdr_pkg::*;

  // A stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_key_valid_i) &&
      $stable(out_key_index_i) && $stable(out_key_char_i))
  else $error("result word changed while stalled");

  // An empty report carries zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_key_valid_i |-> out_key_index_i == '0 && out_key_char_i == '0)
  else $error("empty report with nonzero fields");

  // A report carries the legend of its position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_key_valid_i |-> out_key_char_i == legend_of(out_key_index_i))
  else $error("reported legend does not match position");

  // Every key of the pad has a printable legend
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_key_valid_i |-> out_key_char_i != '0)
  else $error("report without legend");

endmodule

bind keypad_scan_debounce_repeat_core kpsdr_checker u_kpsdr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_key_valid_i (out_o.key_valid),
  .out_key_index_i (out_o.key_index),
  .out_key_char_i  (out_o.key_char)
);

`default_nettype wire

@@ tb/keypad_report_checker.sv @@
module keypad_report_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  kpsdr_cfg_if        cfg_i,
  kpsdr_in_if         poll_i,
  kpsdr_out_if        res_i,
  output int unsigned fail_count_o,
  output int unsigned waiting_o
);
  import kpsdr_pkg::*;

  typedef struct packed {
    logic      hit;
    key_pos_t  pos;
    key_char_t ch;
  } key_report_t;

  // Legends in position order, row 0 first
  localparam logic [8*16-1:0] LEGEND_TEXT = "123A456B789C*0#D";

  ms_t         debounce_ms;
  ms_t         repeat_ms;
  key_code_t   pend_key;
  tick_t       pend_since;
  key_code_t   shown_key;
  tick_t       last_at;
  key_report_t report_q [$];
  int unsigned fails;
  int unsigned waiting_q;

  assign fail_count_o = fails;
  assign waiting_o    = waiting_q;

  // Scan columns outer, rows inner; position+1 of the first key down, 0 when none
  function automatic key_code_t first_down(key_map_t map);
    key_code_t code;
    int        pos;
    code = '0;
    for (int c = 0; c < KEY_COLS; c++) begin
      for (int r = 0; r < KEY_ROWS; r++) begin
        pos = r * KEY_COLS + c;
        if (code == '0 && pos < MAP_W && map[pos]) begin
          code = key_code_t'(pos + 1);
        end
      end
    end
    return code;
  endfunction

  function automatic key_char_t legend_char(key_pos_t pos);
    int r;
    int c;
    r = int'(pos) / KEY_COLS;
    c = int'(pos) % KEY_COLS;
    if (r < 4 && c < 4) begin
      return key_char_t'(LEGEND_TEXT[8*(15 - (r*4 + c)) +: 8]);
    end
    return '0;
  endfunction

  // Advance the debounce and repeat state by one poll and give its report
  function automatic key_report_t next_report(key_map_t map, tick_t now);
    key_report_t rep;
    key_code_t   code;
    tick_t       held;
    tick_t       since_last;
    rep        = '0;
    code       = first_down(map);
    held       = now - pend_since;
    since_last = now - last_at;
    if (code == '0) begin
      pend_key   = '0;
      pend_since = '0;
    end else if (code != pend_key) begin
      pend_key   = code;
      pend_since = now;
    end else if (held > tick_t'(debounce_ms) &&
                 (since_last > tick_t'(repeat_ms) || shown_key != code)) begin
      shown_key  = code;
      last_at    = now;
      pend_since = now;
      rep.hit    = 1'b1;
      rep.pos    = key_pos_t'(code - 1);
      rep.ch     = legend_char(rep.pos);
    end
    return rep;
  endfunction

  // Watch the three channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    key_report_t want;
    if (!rst_ni) begin
      debounce_ms = DEBOUNCE_RST;
      repeat_ms   = REPEAT_RST;
      pend_key    = '0;
      pend_since  = '0;
      shown_key   = '0;
      last_at     = '0;
      report_q.delete();
      waiting_q  <= 0;
    end else begin
      // Apply register writes; keep the low bits, drop unknown indexes
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_IDX_DEBOUNCE: debounce_ms = cfg_i.data[MS_W-1:0];
          CFG_IDX_REPEAT:   repeat_ms   = cfg_i.data[MS_W-1:0];
          default: ;
        endcase
      end
      // Predict each accepted poll word
      if (poll_i.valid && poll_i.ready) begin
        report_q.push_back(next_report(poll_i.key_map, poll_i.now_ms));
      end
      // Compare each accepted result word with the oldest prediction
      if (res_i.valid && res_i.ready) begin
        if (report_q.size() == 0) begin
          $error("result word with no poll waiting");
          fails++;
        end else begin
          want = report_q.pop_front();
          if (res_i.key_valid !== want.hit) begin
            $error("key_valid: expected %0d, got %0d", want.hit, res_i.key_valid);
            fails++;
          end
          if (res_i.key_index !== want.pos) begin
            $error("key_index: expected %0d, got %0d", want.pos, res_i.key_index);
            fails++;
          end
          if (res_i.key_char !== want.ch) begin
            $error("key_char: expected 0x%0h, got 0x%0h", want.ch, res_i.key_char);
            fails++;
          end
        end
      end
      waiting_q <= report_q.size();
    end
  end

endmodule

@@ tb/tb.sv @@
module tb;
  import kpsdr_pkg::*;

  localparam int          RANDOM_POLLS = 750;
  localparam int          QUIET_FROM   = 650;
  localparam int unsigned CYCLE_LIMIT  = 300000;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned waiting;
  int unsigned cycle_count;
  int          polls_sent;
  int          stall_left;
  logic        idle_on;
  logic        quiet;
  tick_t       now_tick;
  ms_t         db_cur;
  ms_t         rp_cur;

  kpsdr_cfg_if cfg_bus ();
  kpsdr_in_if  poll_bus ();
  kpsdr_out_if res_bus ();

  keypad_scan_debounce_repeat_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (poll_bus),
    .out_o  (res_bus)
  );

  keypad_report_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_bus),
    .poll_i       (poll_bus),
    .res_i        (res_bus),
    .fail_count_o (fail_count),
    .waiting_o    (waiting)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Stall the result side in random bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      res_bus.ready <= 1'b0;
    end else if (!quiet && idle_on && $urandom_range(0, 7) == 0) begin
      stall_left    <= $urandom_range(0, 10);
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= 1'b1;
    end
  end

  // Send one poll word, after an optional idle burst
  task automatic send_poll(key_map_t map, tick_t t);
    int gap;
    gap = 0;
    if (!quiet && idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
    end
    if (gap != 0) begin
      poll_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    poll_bus.valid   <= 1'b1;
    poll_bus.key_map <= map;
    poll_bus.now_ms  <= t;
    do @(posedge clk_i); while (poll_bus.ready !== 1'b1);
    polls_sent++;
  endtask

  // Drop valid and hold until every result word is back
  task automatic drain();
    poll_bus.valid <= 1'b0;
    do @(posedge clk_i); while (waiting != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
  endtask

  // Write both registers on an idle block, junk in the upper bits, sometimes also an unknown index
  task automatic configure(ms_t db, ms_t rp);
    drain();
    write_reg(CFG_IDX_DEBOUNCE, {16'($urandom), db});
    write_reg(CFG_IDX_REPEAT, {16'($urandom), rp});
    if ($urandom_range(0, 1) == 0) begin
      write_reg(cfg_idx_t'($urandom_range(int'(CFG_IDX_REPEAT) + 1, 255)), $urandom);
    end
    cfg_bus.valid <= 1'b0;
    db_cur = db;
    rp_cur = rp;
  endtask

  function automatic key_map_t one_key();
    return key_map_t'(1) << $urandom_range(0, MAP_W - 1);
  endfunction

  // Tick advance, biased to the debounce and repeat boundaries
  function automatic tick_t step_ms();
    tick_t d;
    case ($urandom_range(0, 11))
      0:       d = '0;
      1:       d = 1;
      2:       d = tick_t'(db_cur);
      3:       d = tick_t'(db_cur) + 1;
      4:       d = tick_t'(rp_cur);
      5:       d = tick_t'(rp_cur) + 1;
      6:       d = tick_t'(db_cur) + tick_t'($urandom_range(1, 8));
      7, 8:    d = tick_t'($urandom_range(0, int'(db_cur) + int'(rp_cur) + 2));
      9:       d = tick_t'($urandom);
      10:      d = -tick_t'($urandom_range(1, 100));
      default: d = tick_t'(rp_cur) - tick_t'(db_cur);
    endcase
    return d;
  endfunction

  // Hold a key, a chord or noise for a few polls, then mostly release
  task automatic key_session();
    key_map_t map;
    int       kind;
    int       polls;
    if (polls_sent >= QUIET_FROM) begin
      quiet <= 1'b1;
    end
    idle_on <= ($urandom_range(0, 3) != 0);
    kind  = $urandom_range(0, 9);
    polls = $urandom_range(1, 12);
    if (kind <= 5) begin
      map = one_key();
    end else if (kind <= 7) begin
      map = one_key() | one_key() | ($urandom_range(0, 1) ? one_key() : '0);
    end else begin
      map = key_map_t'($urandom);
    end
    for (int k = 0; k < polls; k++) begin
      if (kind == 9) begin
        map = key_map_t'($urandom);
      end else if ($urandom_range(0, 9) == 0) begin
        map = one_key();
      end
      now_tick += step_ms();
      send_poll(map, now_tick);
    end
    if ($urandom_range(0, 3) != 0) begin
      repeat ($urandom_range(1, 2)) begin
        now_tick += step_ms();
        send_poll('0, now_tick);
      end
    end
  endtask

  initial begin
    ms_t db_set [6];
    ms_t rp_set [6];
    db_set = '{16'd0, 16'hFFFF, 16'd5, DEBOUNCE_RST, ms_t'($urandom_range(0, 300)), 16'd1};
    rp_set = '{16'd0, 16'hFFFF, 16'd40, REPEAT_RST, ms_t'($urandom_range(0, 1000)), 16'd0};
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    cycle_count      = 0;
    polls_sent       = 0;
    stall_left       = 0;
    idle_on          = 1'b1;
    quiet            = 1'b0;
    now_tick         = '0;
    db_cur           = DEBOUNCE_RST;
    rp_cur           = REPEAT_RST;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = '0;
    cfg_bus.data     = '0;
    poll_bus.valid   = 1'b0;
    poll_bus.key_map = '0;
    poll_bus.now_ms  = '0;
    res_bus.ready    = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Nothing down, then all keys: debounce edge, repeat edge
    send_poll(16'h0000, 32'd0);
    send_poll(16'hFFFF, 32'd1000);
    send_poll(16'hFFFF, 32'd1020);
    send_poll(16'hFFFF, 32'd1021);
    send_poll(16'hFFFF, 32'd1221);
    send_poll(16'hFFFF, 32'd1222);
    // Two keys: column 0 wins over column 1; a new key reports after debounce without waiting for repeat
    send_poll(16'h0012, 32'd1230);
    send_poll(16'h0012, 32'd1251);
    // Release clears the pending key; the same key waits for repeat
    send_poll(16'h0000, 32'd1252);
    send_poll(16'h0012, 32'd1260);
    send_poll(16'h0012, 32'd1290);
    // Tick wraps past zero, then steps back
    send_poll(16'h8000, 32'hFFFF_FFF0);
    send_poll(16'h8000, 32'h0000_0005);
    send_poll(16'h8000, 32'h0000_0004);
    // Last column and bottom row legends
    send_poll(16'h0088, 32'd100);
    send_poll(16'h0088, 32'd200);
    send_poll(16'h4000, 32'd300);
    send_poll(16'h4000, 32'd400);
    send_poll(16'h2000, 32'd500);
    send_poll(16'h2000, 32'd600);
    send_poll(16'h1000, 32'd700);
    send_poll(16'h1000, 32'd800);
    send_poll(16'hFFFE, 32'd900);
    send_poll(16'hFFFE, 32'hFFFF_FFFF);
    send_poll(16'h0000, 32'hFFFF_FFFF);

    // Random sessions over several register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      configure(db_set[ph], rp_set[ph]);
      while (polls_sent < 25 + (ph + 1) * (RANDOM_POLLS / 6)) begin
        key_session();
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // End a hung run
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ files.f @@
sv/kpsdr_pkg.sv
sv/kpsdr_if.sv
sv/keypad_scan_debounce_repeat_core.sv
sv/kpsdr_checker.sv
tb/keypad_report_checker.sv
tb/tb.sv
